### rtl/core/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types and constants of the UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam int RC_W      = 11;
	localparam int MAX_RINGS = 1024;
	localparam int DIV_STEPS = 33;
	localparam int Q_W       = DIV_STEPS + 1;

	// Q30 coefficients of the odd sine polynomial
	localparam logic [30:0] SIN_A1 = 31'd1686629713;
	localparam logic [30:0] SIN_A3 = 31'd693598668;
	localparam logic [30:0] SIN_A5 = 31'd85569306;
	localparam logic [30:0] SIN_A7 = 31'd5026995;
	localparam logic [30:0] SIN_A9 = 31'd172272;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	typedef enum logic [2:0] {
		REG_RING_COUNT = 3'd0,
		REG_HEMISPHERE = 3'd1,
		REG_CENTER_X   = 3'd2,
		REG_CENTER_Y   = 3'd3,
		REG_CENTER_Z   = 3'd4,
		REG_RADIUS     = 3'd5
	} reg_idx_t;

	// state handed from one divider cell to the next
	typedef struct packed {
		logic            valid;
		logic [RC_W-1:0] ring;
		logic [RC_W-1:0] point;
		logic [RC_W-1:0] rem_r;
		logic [RC_W-1:0] rem_p;
		logic [Q_W-1:0]  q_r;
		logic [Q_W-1:0]  q_p;
	} div_t;

endpackage

### rtl/core/uvs_div_cell.sv
// ----------------------------------------------------------------------------
// uvs_div_cell
// One restoring-division step for the ring and point quotients.
// ----------------------------------------------------------------------------
module uvs_div_cell
	import uvs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [RC_W-1:0] rc,
	input  div_t            d_in,
	output div_t            d_out
);

	logic [RC_W:0]   sh_r, sh_p, df_r, df_p;
	logic            ge_r, ge_p;
	div_t            nx;
	div_t            d_q;

	always_comb begin
		sh_r = {d_in.rem_r, 1'b0};
		sh_p = {d_in.rem_p, 1'b0};
		df_r = sh_r - {1'b0, rc};
		df_p = sh_p - {1'b0, rc};
		ge_r = sh_r >= {1'b0, rc};
		ge_p = sh_p >= {1'b0, rc};
		nx       = d_in;
		nx.rem_r = ge_r ? df_r[RC_W-1:0] : sh_r[RC_W-1:0];
		nx.rem_p = ge_p ? df_p[RC_W-1:0] : sh_p[RC_W-1:0];
		nx.q_r   = {d_in.q_r[Q_W-2:0], ge_r};
		nx.q_p   = {d_in.q_p[Q_W-2:0], ge_p};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= '0;
		end else if (en) begin
			d_q <= nx;
		end
	end

	assign d_out = d_q;

endmodule

### rtl/core/uvs_sine.sv
// ----------------------------------------------------------------------------
// uvs_sine
// Six-stage quarter-wave sine: odd polynomial in Horner form, Q30.
// ----------------------------------------------------------------------------
module uvs_sine
	import uvs_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] t,
	input  logic        neg_half,
	output logic [30:0] mag,
	output logic        neg
);

	logic [30:0] t_s1, t_s2, t_s3, t_s4, t_s5;
	logic [30:0] t2_s1, t2_s2, t2_s3, t2_s4;
	logic [30:0] p_s2, p_s3, p_s4, p_s5;
	logic [4:0]  nh_q;
	logic [30:0] mag_s6;
	logic        neg_s6;
	logic [61:0] sq, m2, m3, m4, m5, m6;
	logic [30:0] r6;

	always_comb begin
		sq = {31'd0, t} * {31'd0, t};
		m2 = {31'd0, SIN_A9} * {31'd0, t2_s1};
		m3 = {31'd0, p_s2} * {31'd0, t2_s2};
		m4 = {31'd0, p_s3} * {31'd0, t2_s3};
		m5 = {31'd0, p_s4} * {31'd0, t2_s4};
		m6 = {31'd0, p_s5} * {31'd0, t_s5};
		r6 = (m6[61:30] > {1'b0, Q30_ONE}) ? Q30_ONE : m6[60:30];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= t;
			t2_s1  <= sq[60:30];
			t_s2   <= t_s1;
			t2_s2  <= t2_s1;
			p_s2   <= SIN_A7 - m2[60:30];
			t_s3   <= t_s2;
			t2_s3  <= t2_s2;
			p_s3   <= SIN_A5 - m3[60:30];
			t_s4   <= t_s3;
			t2_s4  <= t2_s3;
			p_s4   <= SIN_A3 - m4[60:30];
			t_s5   <= t_s4;
			p_s5   <= SIN_A1 - m5[60:30];
			nh_q   <= {nh_q[3:0], neg_half};
			mag_s6 <= r6;
			neg_s6 <= nh_q[4] && (r6 != 31'd0);
		end
	end

	assign mag = mag_s6;
	assign neg = neg_s6;

endmodule

### rtl/core/uv_sphere_vertex_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Normal, vertex, texture coordinates and strip indices of one UV sphere
// grid point per request.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  s_axis    in         tvalid/tready             ring_index, point_index
//  m_axis    out        tvalid/tready             vertex record, has_strip in tuser
//  cfg       in         cfg_we                    cfg_index, cfg_data
//
//  One request per cycle while s_axis_tready is high. Each request passes
//  the 33-cell divider chain (one quotient bit per cell), the phase
//  register, the six-stage sine units, two multiply stages and the
//  output register. Reset restores the register defaults. A stalled
//  output is held in a skid register; the pipeline freezes only when
//  both are occupied. A ring count of zero swallows the request.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator
	import uvs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [23:0]  s_axis_tdata,   // ring_index, point_index
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [247:0] m_axis_tdata,   // normal_x, normal_y, normal_z, vertex_x,
	                                     // vertex_y, vertex_z, tex_u, tex_v,
	                                     // vertex_slot, strip_upper_index,
	                                     // strip_lower_index
	output logic [0:0]   m_axis_tuser,   // has_strip
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	typedef struct packed {
		logic        valid;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic [20:0] slot;
		logic [20:0] upper;
		logic [20:0] lower;
		logic        has_strip;
	} meta_t;

	typedef struct packed {
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic [20:0] slot;
		logic [20:0] upper;
		logic [20:0] lower;
		logic        has_strip;
	} out_t;

	// configuration
	logic [RC_W-1:0] ring_count_q;
	logic            hemi_q;
	logic [31:0]     cx_q, cy_q, cz_q;
	logic [30:0]     radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q <= RC_W'(16);
			hemi_q       <= 1'b0;
			cx_q         <= '0;
			cy_q         <= '0;
			cz_q         <= '0;
			radius_q     <= 31'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RING_COUNT: ring_count_q <= cfg_data[RC_W-1:0];
				REG_HEMISPHERE: hemi_q       <= cfg_data[0];
				REG_CENTER_X:   cx_q         <= cfg_data;
				REG_CENTER_Y:   cy_q         <= cfg_data;
				REG_CENTER_Z:   cz_q         <= cfg_data;
				REG_RADIUS:     radius_q     <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	logic [RC_W-1:0] rc;
	assign rc = (ring_count_q > RC_W'(MAX_RINGS)) ? RC_W'(MAX_RINGS) : ring_count_q;

	logic en;
	logic spare_valid_q;
	assign en            = !spare_valid_q;
	assign s_axis_tready = en;

	// divider chain entry: integer quotient bit, then the remainder
	div_t            d_init;
	logic [RC_W-1:0] ring_c, point_c;
	div_t            chain [DIV_STEPS+1];

	always_comb begin
		ring_c  = (s_axis_tdata[10:0] > rc) ? rc : s_axis_tdata[10:0];
		point_c = (s_axis_tdata[21:11] > rc) ? rc : s_axis_tdata[21:11];
		d_init.valid = s_axis_tvalid && (rc != '0);
		d_init.ring  = ring_c;
		d_init.point = point_c;
		d_init.rem_r = (ring_c == rc) ? '0 : ring_c;
		d_init.rem_p = (point_c == rc) ? '0 : point_c;
		d_init.q_r   = {{(Q_W-1){1'b0}}, ring_c == rc};
		d_init.q_p   = {{(Q_W-1){1'b0}}, point_c == rc};
	end

	assign chain[0] = d_init;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		uvs_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.rc     (rc),
			.d_in   (chain[i]),
			.d_out  (chain[i+1])
		);
	end

	// phase stage
	div_t        dv;
	logic [33:0] lat_sum;
	logic [34:0] lonf_sum;
	logic [33:0] lonh_sum;
	logic [18:0] tu_sum, tv_sum;
	logic [31:0] lat_ph, lon_ph, lat_cph, lon_cph;
	logic [22:0] slot_w;
	meta_t       meta_d;

	function automatic logic [30:0] fold(input logic [31:0] ph);
		return ph[30] ? (Q30_ONE - {1'b0, ph[29:0]}) : {1'b0, ph[29:0]};
	endfunction

	always_comb begin
		dv       = chain[DIV_STEPS];
		lat_sum  = {1'b0, dv.q_r[33:1]} + 34'd1;
		lonf_sum = {1'b0, dv.q_p} + 35'd1;
		lonh_sum = {1'b0, dv.q_p[33:1]} + 34'd1;
		tu_sum   = {1'b0, dv.q_p[33:16]} + 19'd1;
		tv_sum   = {1'b0, dv.q_r[33:16]} + 19'd1;
		lat_ph   = lat_sum[32:1] - 32'h4000_0000;
		lon_ph   = hemi_q ? (lonh_sum[32:1] + 32'h4000_0000) : lonf_sum[32:1];
		lat_cph  = lat_ph + 32'h4000_0000;
		lon_cph  = lon_ph + 32'h4000_0000;
		slot_w   = ({12'd0, rc} + 23'd1) * {12'd0, dv.ring} + {12'd0, dv.point};
		meta_d.valid     = dv.valid;
		meta_d.tex_u     = tu_sum[17:1];
		meta_d.tex_v     = tv_sum[17:1];
		meta_d.slot      = slot_w[20:0];
		meta_d.has_strip = dv.ring < rc;
		meta_d.upper     = meta_d.has_strip ?
		                   (slot_w[20:0] + 21'(rc) + 21'd1) : '0;
		meta_d.lower     = meta_d.has_strip ? slot_w[20:0] : '0;
	end

	meta_t       meta_s1;
	logic [30:0] t_sl_s1, t_cl_s1, t_so_s1, t_co_s1;
	logic        h_sl_s1, h_cl_s1, h_so_s1, h_co_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
		end else if (en) begin
			meta_s1 <= meta_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_sl_s1 <= fold(lat_ph);
			t_cl_s1 <= fold(lat_cph);
			t_so_s1 <= fold(lon_ph);
			t_co_s1 <= fold(lon_cph);
			h_sl_s1 <= lat_ph[31];
			h_cl_s1 <= lat_cph[31];
			h_so_s1 <= lon_ph[31];
			h_co_s1 <= lon_cph[31];
		end
	end

	// sine units
	logic [30:0] sl_mag, cl_mag, so_mag, co_mag;
	logic        sl_neg, cl_neg, so_neg, co_neg;

	uvs_sine u_sin_lat (.clk(clk), .en(en), .t(t_sl_s1), .neg_half(h_sl_s1),
		.mag(sl_mag), .neg(sl_neg));
	uvs_sine u_cos_lat (.clk(clk), .en(en), .t(t_cl_s1), .neg_half(h_cl_s1),
		.mag(cl_mag), .neg(cl_neg));
	uvs_sine u_sin_lon (.clk(clk), .en(en), .t(t_so_s1), .neg_half(h_so_s1),
		.mag(so_mag), .neg(so_neg));
	uvs_sine u_cos_lon (.clk(clk), .en(en), .t(t_co_s1), .neg_half(h_co_s1),
		.mag(co_mag), .neg(co_neg));

	// carry the metadata alongside the sine stages
	meta_t meta_pipe_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) meta_pipe_q[i] <= '0;
		end else if (en) begin
			meta_pipe_q[0] <= meta_s1;
			for (int i = 1; i < 6; i++) meta_pipe_q[i] <= meta_pipe_q[i-1];
		end
	end

	// normal stage
	logic [61:0] px, pz;
	logic [31:0] py;
	logic [14:0] nxm, nym, nzm;

	always_comb begin
		px  = ({31'd0, cl_mag} * {31'd0, co_mag}) + (62'd1 << 45);
		pz  = ({31'd0, cl_mag} * {31'd0, so_mag}) + (62'd1 << 45);
		py  = {1'b0, sl_mag} + 32'd32768;
		nxm = px[60:46];
		nzm = pz[60:46];
		nym = py[30:16];
	end

	meta_t       meta_s8;
	logic [14:0] nxm_s8, nym_s8, nzm_s8;
	logic        nxn_s8, nyn_s8, nzn_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s8 <= '0;
		end else if (en) begin
			meta_s8 <= meta_pipe_q[5];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nxm_s8 <= nxm;
			nym_s8 <= nym;
			nzm_s8 <= nzm;
			nxn_s8 <= (cl_neg != co_neg) && (nxm != '0);
			nzn_s8 <= (cl_neg != so_neg) && (nzm != '0);
			nyn_s8 <= sl_neg && (nym != '0);
		end
	end

	// radius times normal
	function automatic logic [32:0] scale(input logic [30:0] r, input logic [14:0] m);
		logic [46:0] p;
		p = ({16'd0, r} * {32'd0, m}) + 47'd8192;
		return p[46:14];
	endfunction

	function automatic logic [15:0] enc16(input logic [14:0] m, input logic n);
		return n ? (16'd0 - {1'b0, m}) : {1'b0, m};
	endfunction

	meta_t       meta_s9;
	logic [32:0] ox_s9, oy_s9, oz_s9;
	logic        nxn_s9, nyn_s9, nzn_s9;
	logic [15:0] nx_s9, ny_s9, nz_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s9 <= '0;
		end else if (en) begin
			meta_s9 <= meta_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ox_s9  <= scale(radius_q, nxm_s8);
			oy_s9  <= scale(radius_q, nym_s8);
			oz_s9  <= scale(radius_q, nzm_s8);
			nxn_s9 <= nxn_s8;
			nyn_s9 <= nyn_s8;
			nzn_s9 <= nzn_s8;
			nx_s9  <= enc16(nxm_s8, nxn_s8);
			ny_s9  <= enc16(nym_s8, nyn_s8);
			nz_s9  <= enc16(nzm_s8, nzn_s8);
		end
	end

	// center plus offset, saturated
	function automatic logic [31:0] place(input logic [31:0] c, input logic [32:0] o,
		input logic n);
		logic signed [34:0] v;
		v = n ? (35'(signed'(c)) - signed'({2'b0, o}))
		      : (35'(signed'(c)) + signed'({2'b0, o}));
		if (v > 35'sh0_7FFF_FFFF) return 32'h7FFF_FFFF;
		else if (v < -35'sh0_8000_0000) return 32'h8000_0000;
		else return v[31:0];
	endfunction

	out_t up_d;
	logic up_v;

	always_comb begin
		up_v            = meta_s9.valid && en;
		up_d.nx         = nx_s9;
		up_d.ny         = ny_s9;
		up_d.nz         = nz_s9;
		up_d.vx         = place(cx_q, ox_s9, nxn_s9);
		up_d.vy         = place(cy_q, oy_s9, nyn_s9);
		up_d.vz         = place(cz_q, oz_s9, nzn_s9);
		up_d.tex_u      = meta_s9.tex_u;
		up_d.tex_v      = meta_s9.tex_v;
		up_d.slot       = meta_s9.slot;
		up_d.upper      = meta_s9.upper;
		up_d.lower      = meta_s9.lower;
		up_d.has_strip  = meta_s9.has_strip;
	end

	// output register with skid
	out_t out_q, spare_q;
	logic out_valid_q;
	logic take;

	assign take = m_axis_tready || !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q   <= spare_valid_q || up_v;
			spare_valid_q <= 1'b0;
		end else if (up_v) begin
			spare_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= spare_valid_q ? spare_q : up_d;
		end else if (up_v) begin
			spare_q <= up_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.has_strip;
	assign m_axis_tdata  = {7'd0, out_q.lower, out_q.upper, out_q.slot,
	                        out_q.tex_v, out_q.tex_u, out_q.vz, out_q.vy, out_q.vx,
	                        out_q.nz, out_q.ny, out_q.nx};

endmodule
